@@ src/imvc_pkg.sv @@
// Package for the induction motor vector control step.
// Holds fixed-point helpers, opcodes and controller state type; no dependencies.
package imvc_pkg;

	localparam int NUM_REGS = 8;
	localparam logic [2:0] REG_KP   = 3'd0;
	localparam logic [2:0] REG_KI   = 3'd1;
	localparam logic [2:0] REG_DT   = 3'd2;
	localparam logic [2:0] REG_LM   = 3'd3;
	localparam logic [2:0] REG_LR   = 3'd4;
	localparam logic [2:0] REG_TAU  = 3'd5;
	localparam logic [2:0] REG_NF   = 3'd6;
	localparam logic [2:0] REG_SYNC = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_OUT
	} ctrl_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic start;
		logic [5:0] step;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic last_step;
	} dp_stat_t;

	localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > 65'sd9223372036854775807) return S64_MAX;
		if (s < -65'sd9223372036854775808) return S64_MIN;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s > 65'sd9223372036854775807) return S64_MAX;
		if (s < -65'sd9223372036854775808) return S64_MIN;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] clampv(input logic signed [63:0] v,
		input logic signed [63:0] lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] sat_mag(input logic [63:0] m, input logic neg);
		logic [63:0] t;
		t = (m > 64'h7fff_ffff_ffff_ffff) ? 64'h7fff_ffff_ffff_ffff : m;
		return neg ? -$signed(t) : $signed(t);
	endfunction

endpackage

@@ src/imvc_mul.sv @@
// Multi-cycle signed fixed-point multiplier: 64x64 magnitude product built from
// four 32x32 partial products, one per cycle. Depends on imvc_pkg.
module imvc_mul #(
	parameter int FRAC_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic done,
	output logic signed [63:0] prod
);
	import imvc_pkg::*;

	logic [63:0] x_q, y_q;
	logic neg_q;
	logic [127:0] acc_q;
	logic [2:0] cnt_q;
	logic [63:0] pp;
	logic [31:0] xs, ys;
	logic [127:0] pp_ext;
	logic [63:0] m;

	always_comb begin
		xs = cnt_q[1] ? x_q[63:32] : x_q[31:0];
		ys = cnt_q[0] ? y_q[63:32] : y_q[31:0];
		pp = 64'(xs) * 64'(ys);
		pp_ext = 128'(pp) << (7'(cnt_q[1] + cnt_q[0]) * 7'd32);
		if ((acc_q >> (64 + FRAC_BITS)) != 128'd0)
			m = 64'h7fff_ffff_ffff_ffff;
		else
			m = 64'(acc_q >> FRAC_BITS);
		prod = sat_mag(m, neg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd4;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= 3'd0;
			end else if (cnt_q != 3'd4) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd3)
					done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= mag(a);
			y_q <= mag(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (cnt_q != 3'd4) begin
			acc_q <= acc_q + pp_ext;
		end
	end

endmodule

@@ src/imvc_div.sv @@
// Serial restoring divider: (n * 2^FRAC_BITS) / d, one quotient bit per cycle,
// with zero-divisor and overflow saturation. Depends on imvc_pkg.
module imvc_div #(
	parameter int FRAC_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [63:0] n,
	input  logic signed [63:0] d,
	output logic done,
	output logic signed [63:0] quot,
	output logic sat
);
	import imvc_pkg::*;

	logic [127:0] num_q;
	logic [64:0] rem_q;
	logic [127:0] q_q;
	logic [63:0] dm_q;
	logic neg_q, zero_n_q, zero_d_q;
	logic [7:0] cnt_q;
	logic busy_q;
	logic [64:0] rem_sh;
	logic ovf;

	always_comb begin
		rem_sh = {rem_q[63:0], num_q[127]};
		ovf = (q_q[127:64] != 64'd0) || q_q[63];
		if (zero_n_q) begin
			quot = '0;
			sat = 1'b0;
		end else if (zero_d_q) begin
			quot = neg_q ? -S64_MAX : S64_MAX;
			sat = 1'b1;
		end else begin
			quot = sat_mag(ovf ? 64'h7fff_ffff_ffff_ffff : q_q[63:0], neg_q);
			sat = ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 8'd127;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 8'd1;
				if (cnt_q == 8'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= 128'(mag(n)) << FRAC_BITS;
			rem_q <= '0;
			q_q <= '0;
			dm_q <= mag(d);
			neg_q <= n[63] ^ d[63];
			zero_n_q <= (n == 64'sd0);
			zero_d_q <= (d == 64'sd0);
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (rem_sh >= {1'b0, dm_q}) begin
				rem_q <= rem_sh - {1'b0, dm_q};
				q_q <= {q_q[126:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q <= {q_q[126:0], 1'b0};
			end
		end
	end

endmodule

@@ src/imvc_datapath.sv @@
// Datapath: scratch registers, state registers and the shared multiplier and
// divider, driven one micro-step at a time by the controller. Depends on imvc_pkg.
module imvc_datapath #(
	parameter int FRAC_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  imvc_pkg::dp_cmd_t cmd,
	output imvc_pkg::dp_stat_t stat,
	input  logic [47:0] regs [imvc_pkg::NUM_REGS],
	input  logic signed [31:0] in_id,
	input  logic signed [31:0] in_iq,
	input  logic signed [31:0] in_sp,
	input  logic signed [31:0] in_spt,
	output logic [32*4+64+1-1:0] result
);
	import imvc_pkg::*;

	localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] LIM15 = 64'sd15 <<< FRAC_BITS;
	localparam logic signed [63:0] LIM30 = 64'sd30 <<< FRAC_BITS;
	localparam logic signed [63:0] LIM2 = 64'sd2 <<< FRAC_BITS;
	localparam logic signed [63:0] B2000 = 64'sd2000 <<< FRAC_BITS;
	localparam logic signed [63:0] B2500 = 64'sd2500 <<< FRAC_BITS;
	localparam logic signed [63:0] B3000 = 64'sd3000 <<< FRAC_BITS;
	localparam logic signed [63:0] C12 = 64'sd12 <<< FRAC_BITS;
	localparam logic [127:0] ONE_U = 128'd1 << FRAC_BITS;
	localparam logic signed [63:0] K0P0002 = 64'((2 * ONE_U + 128'd5000) / 128'd10000);
	localparam logic signed [63:0] K1P4 = 64'((14 * ONE_U + 128'd5) / 128'd10);
	localparam logic signed [63:0] K0P00036 = 64'((36 * ONE_U + 128'd50000) / 128'd100000);
	localparam logic signed [63:0] K1P8 = 64'((18 * ONE_U + 128'd5) / 128'd10);
	localparam logic signed [63:0] K0P00042 = 64'((42 * ONE_U + 128'd50000) / 128'd100000);
	localparam logic signed [63:0] K1P98 = 64'((198 * ONE_U + 128'd50) / 128'd100);
	localparam logic signed [63:0] K0P001 = 64'((ONE_U + 128'd500) / 128'd1000);

	logic signed [63:0] s_int_q, f_int_q, prev_flux_q;
	logic [63:0] angle_q;
	logic signed [63:0] t_q [3];
	logic signed [63:0] torque_q, flux_q, fref_q, iqr_q, idr_q, err_q;
	logic flag_q;
	logic signed [63:0] ma, mb, dn, dd;
	logic mul_go, div_go, mul_done, div_done, div_sat;
	logic signed [63:0] prod, quot;
	logic signed [63:0] kp, ki, dt, lm, lr, tau, nf, sy;
	logic signed [63:0] id, iq, sp, spt;
	logic signed [63:0] inc;
	logic waiting_q;

	function automatic logic signed [63:0] cfg_q(input logic [47:0] v);
		if (FRAC_BITS >= 32) return 64'(v) << (FRAC_BITS - 32);
		return 64'(v) >> (32 - FRAC_BITS);
	endfunction

	function automatic logic [31:0] out_q16(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v >>> (FRAC_BITS - 16);
		if (r > 64'sd2147483647) return 32'h7fff_ffff;
		if (r < -64'sd2147483648) return 32'h8000_0000;
		return r[31:0];
	endfunction

	always_comb begin
		kp = cfg_q(regs[REG_KP]);
		ki = cfg_q(regs[REG_KI]);
		dt = cfg_q(regs[REG_DT]);
		lm = cfg_q(regs[REG_LM]);
		lr = cfg_q(regs[REG_LR]);
		tau = cfg_q(regs[REG_TAU]);
		nf = cfg_q(regs[REG_NF]);
		sy = cfg_q(regs[REG_SYNC]);
		id = 64'(in_id) <<< (FRAC_BITS - 16);
		iq = 64'(in_iq) <<< (FRAC_BITS - 16);
		sp = 64'(in_sp) <<< (FRAC_BITS - 16);
		spt = 64'(in_spt) <<< (FRAC_BITS - 16);
		if (FRAC_BITS >= 32)
			inc = prod >>> (FRAC_BITS - 32);
		else if (prod > (S64_MAX >>> (32 - FRAC_BITS)))
			inc = S64_MAX;
		else if (prod < -(S64_MAX >>> (32 - FRAC_BITS)))
			inc = S64_MIN;
		else
			inc = prod <<< (32 - FRAC_BITS);
	end

	// Operand selection per micro-step. Steps issue either a multiply or a divide.
	always_comb begin
		ma = '0;
		mb = '0;
		dn = '0;
		dd = '0;
		mul_go = 1'b0;
		div_go = 1'b0;
		unique case (cmd.step)
			6'd0: begin mul_go = 1'b1; ma = dt; mb = err_q; end
			6'd1: begin mul_go = 1'b1; ma = sadd(s_int_q, t_q[0]); mb = ki; end
			6'd2: begin mul_go = 1'b1; ma = err_q; mb = kp; end
			6'd3: begin
				mul_go = 1'b1;
				ma = (spt <= B2500) ? -K0P0002 : (spt <= B3000) ? -K0P00036 : -K0P00042;
				mb = spt;
			end
			6'd4: begin
				mul_go = 1'b1;
				ma = sadd(t_q[0],
					(spt <= B2500) ? K1P4 : (spt <= B3000) ? K1P8 : K1P98);
				mb = nf;
			end
			6'd5: begin mul_go = 1'b1; ma = tau; mb = prev_flux_q; end
			6'd6: begin mul_go = 1'b1; ma = dt; mb = lm; end
			6'd7: begin mul_go = 1'b1; ma = id; mb = t_q[0]; end
			6'd8: begin div_go = 1'b1; dn = sadd(t_q[1], t_q[0]); dd = sadd(dt, tau); end
			6'd9: begin mul_go = 1'b1; ma = lm; mb = iq; end
			6'd10: begin mul_go = 1'b1; ma = tau; mb = flux_q; end
			6'd11: begin div_go = 1'b1; dn = t_q[1]; dd = t_q[0]; end
			6'd12: begin mul_go = 1'b1; ma = sadd(t_q[0], sy); mb = dt; end
			6'd13: begin mul_go = 1'b1; ma = C12; mb = lm; end
			6'd14: begin
				mul_go = 1'b1;
				ma = t_q[1];
				mb = (flux_q < K0P001) ? K0P001 : flux_q;
			end
			6'd15: begin mul_go = 1'b1; ma = sadd(lr, lr); mb = torque_q; end
			6'd16: begin div_go = 1'b1; dn = t_q[0]; dd = t_q[2]; end
			6'd17: begin mul_go = 1'b1; ma = dt; mb = ssub(fref_q, flux_q); end
			6'd18: begin mul_go = 1'b1; ma = sadd(f_int_q, t_q[0]); mb = ki; end
			6'd19: begin mul_go = 1'b1; ma = ssub(fref_q, flux_q); mb = kp; end
			6'd20: begin
				div_go = 1'b1;
				dn = clampv(sadd(f_int_q, t_q[0]), LIM2);
				dd = lm;
			end
			default: ;
		endcase
		mul_go = mul_go & cmd.start;
		div_go = div_go & cmd.start;
	end

	imvc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(ma), .b(mb),
		.done(mul_done), .prod(prod)
	);

	imvc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .n(dn), .d(dd),
		.done(div_done), .quot(quot), .sat(div_sat)
	);

	assign stat.busy = waiting_q & ~(mul_done | div_done);
	assign stat.last_step = (cmd.step == 6'd20);

	assign result = {flag_q, angle_q, out_q16(flux_q), out_q16(torque_q),
		out_q16(iqr_q), out_q16(idr_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_int_q <= '0;
			f_int_q <= '0;
			prev_flux_q <= '0;
			angle_q <= '0;
			waiting_q <= 1'b0;
		end else begin
			if (cmd.start)
				waiting_q <= 1'b1;
			else if (mul_done | div_done)
				waiting_q <= 1'b0;
			if (mul_done) begin
				unique case (cmd.step)
					6'd1: s_int_q <= clampv(prod, LIM15);
					6'd12: angle_q <= angle_q + inc;
					6'd18: f_int_q <= clampv(prod, ONE_Q);
					default: ;
				endcase
			end
			if (div_done && cmd.step == 6'd8)
				prev_flux_q <= quot;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= ssub(spt, sp);
			flag_q <= 1'b0;
		end
		if (mul_done) begin
			unique case (cmd.step)
				6'd2: torque_q <= clampv(sadd(s_int_q, prod), LIM30);
				6'd4: fref_q <= (spt <= B2000) ? nf : prod;
				6'd5: t_q[1] <= prod;
				6'd6: t_q[0] <= prod;
				6'd7: t_q[0] <= prod;
				6'd9: t_q[1] <= prod;
				6'd13: t_q[1] <= prod;
				6'd14: t_q[2] <= prod;
				default: t_q[0] <= prod;
			endcase
		end
		if (div_done) begin
			flag_q <= flag_q | div_sat;
			unique case (cmd.step)
				6'd8: flux_q <= quot;
				6'd16: iqr_q <= quot;
				6'd20: idr_q <= quot;
				default: t_q[0] <= quot;
			endcase
		end
	end

endmodule

@@ src/imvc_ctrl.sv @@
// Controller state machine that sequences the datapath micro-steps for one sample.
// Depends on imvc_pkg.
module imvc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_req,
	output logic in_take,
	output logic out_req,
	input  logic out_take,
	output imvc_pkg::dp_cmd_t cmd,
	input  imvc_pkg::dp_stat_t stat
);
	import imvc_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [5:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		in_take = 1'b0;
		out_req = 1'b0;
		cmd.start = 1'b0;
		cmd.load = 1'b0;
		cmd.step = step_q;
		unique case (state_q)
			ST_IDLE: begin
				in_take = 1'b1;
				if (in_req) begin
					cmd.load = 1'b1;
					step_d = '0;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.start = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (!stat.busy) begin
					if (stat.last_step) begin
						state_d = ST_OUT;
					end else begin
						step_d = step_q + 6'd1;
						state_d = ST_RUN;
					end
				end
			end
			ST_OUT: begin
				out_req = 1'b1;
				if (out_take)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ src/induction_motor_vector_control_step.sv @@
// Top level of the induction motor vector control step.
// Uses imvc_pkg, imvc_ctrl and imvc_datapath (with imvc_mul and imvc_div).
//
// Input requests on s_axis carry current_d, current_q, speed_meas and speed_target.
// One result request per sample leaves on m_axis. Registers are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write them only while the
// block is idle, as the block itself does not enforce it.
// A sample runs through 21 steps: 17 products on one shared multiplier (four partial
// products each) and four quotients on one serial divider (128 quotient bits each).
// One sample is handled at a time; a new request can be taken in the cycle
// after the result has been taken. If the receiver stalls, the result holds on
// m_axis_tdata. Reset clears the integrators, the previous flux and the angle
// and loads the default registers.
module induction_motor_vector_control_step #(
	parameter int FRAC_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// current_d, current_q, speed_meas, speed_target
	input  logic [127:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// d_current_ref, q_current_ref, torque_cmd, flux_estimate, angle_estimate,
	// div_saturated, zero fill
	output logic [199:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [47:0] cfg_data
);
	import imvc_pkg::*;

	logic [47:0] regs_q [NUM_REGS];
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [192:0] result;
	logic [127:0] in_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_KP] <= 48'd171798691840;
			regs_q[REG_KI] <= 48'd214748364800;
			regs_q[REG_DT] <= 48'd214748;
			regs_q[REG_LM] <= 48'd3477205523;
			regs_q[REG_LR] <= 48'd3615288721;
			regs_q[REG_TAU] <= 48'd446331941;
			regs_q[REG_NF] <= 48'd1288490189;
			regs_q[REG_SYNC] <= 48'd1349303770659;
		end else if (cfg_valid) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			in_q <= s_axis_tdata;
	end

	imvc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_req(s_axis_tvalid), .in_take(s_axis_tready),
		.out_req(m_axis_tvalid), .out_take(m_axis_tready),
		.cmd(cmd), .stat(stat)
	);

	imvc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .regs(regs_q),
		.in_id(s_axis_tvalid && s_axis_tready ? s_axis_tdata[31:0] : in_q[31:0]),
		.in_iq(s_axis_tvalid && s_axis_tready ? s_axis_tdata[63:32] : in_q[63:32]),
		.in_sp(s_axis_tvalid && s_axis_tready ? s_axis_tdata[95:64] : in_q[95:64]),
		.in_spt(s_axis_tvalid && s_axis_tready ? s_axis_tdata[127:96] : in_q[127:96]),
		.result(result)
	);

	assign m_axis_tdata = {7'd0, result};

endmodule
